// ===== rtl/rhcf_pkg.sv =====
// ============================================================================
// ROM header checksum fix-up package
// Shared types, constants and the fixed logo table of the header unit.
// ============================================================================
package rhcf_pkg;

  localparam int unsigned LENGTH_BITS = 23;

  localparam int unsigned POS_W      = 24;
  localparam int unsigned LEN_W      = 25;
  localparam int unsigned BANK_BITS  = 15;
  localparam int unsigned CODE_STEPS = 9;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam logic [POS_W-1:0] LOGO_START  = 24'h000104;
  localparam logic [POS_W-1:0] HDR_START   = 24'h000134;
  localparam logic [POS_W-1:0] TYPE_POS    = 24'h000147;
  localparam logic [POS_W-1:0] SIZE_POS    = 24'h000148;
  localparam logic [POS_W-1:0] HCHK_POS    = 24'h00014D;
  localparam logic [POS_W-1:0] GCHK_HI_POS = 24'h00014E;
  localparam logic [POS_W-1:0] GCHK_LO_POS = 24'h00014F;
  localparam logic [POS_W-1:0] POS_MAX     = 24'hFFFFFF;
  localparam logic [LEN_W-1:0] MIN_LENGTH  = 25'h0000150;
  localparam logic [LEN_W-1:0] BANK_BYTES  = 25'h0008000;
  localparam logic [7:0]       HDR_BASE    = 8'hE7;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [15:0]      global_sum;
    logic [7:0]       header_sum;
    logic [7:0]       orig_type;
    logic [7:0]       orig_size;
    logic [7:0]       stored_hchk;
    logic [15:0]      stored_gchk;
    logic [LEN_W-1:0] length;
    logic             overflow;
  } snap_t;

  function automatic logic [7:0] logo_byte(input logic [5:0] i);
    logic [7:0] v;
    unique case (i)
      6'd0:  v = 8'hCE;  6'd1:  v = 8'hED;  6'd2:  v = 8'h66;  6'd3:  v = 8'h66;
      6'd4:  v = 8'hCC;  6'd5:  v = 8'h0D;  6'd6:  v = 8'h00;  6'd7:  v = 8'h0B;
      6'd8:  v = 8'h03;  6'd9:  v = 8'h73;  6'd10: v = 8'h00;  6'd11: v = 8'h83;
      6'd12: v = 8'h00;  6'd13: v = 8'h0C;  6'd14: v = 8'h00;  6'd15: v = 8'h0D;
      6'd16: v = 8'h00;  6'd17: v = 8'h08;  6'd18: v = 8'h11;  6'd19: v = 8'h1F;
      6'd20: v = 8'h88;  6'd21: v = 8'h89;  6'd22: v = 8'h00;  6'd23: v = 8'h0E;
      6'd24: v = 8'hDC;  6'd25: v = 8'hCC;  6'd26: v = 8'h6E;  6'd27: v = 8'hE6;
      6'd28: v = 8'hDD;  6'd29: v = 8'hDD;  6'd30: v = 8'hD9;  6'd31: v = 8'h99;
      6'd32: v = 8'hBB;  6'd33: v = 8'hBB;  6'd34: v = 8'h67;  6'd35: v = 8'h63;
      6'd36: v = 8'h6E;  6'd37: v = 8'h0E;  6'd38: v = 8'hEC;  6'd39: v = 8'hCC;
      6'd40: v = 8'hDD;  6'd41: v = 8'hDC;  6'd42: v = 8'h99;  6'd43: v = 8'h9F;
      6'd44: v = 8'hBB;  6'd45: v = 8'hB9;  6'd46: v = 8'h33;  6'd47: v = 8'h3E;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/rhcf_in_stage.sv =====
// ============================================================================
// ROM header checksum fix-up input stage
// Registers each accepted input item and holds it until it is consumed.
// ============================================================================
module rhcf_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  rhcf_pkg::in_item_t s_item_i,
  output logic              valid_o,
  output rhcf_pkg::in_item_t item_o,
  input  logic              consume_i
);

  logic               valid_q, valid_d;
  rhcf_pkg::in_item_t item_q;
  logic               load;

  assign s_ready_o = !valid_q || consume_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= s_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/rhcf_accum.sv =====
// ============================================================================
// ROM header checksum fix-up accumulator
// Counts byte positions, keeps the running sums and captured header bytes,
// and hands a snapshot of the final state to the finishing stage.
// ============================================================================
module rhcf_accum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  rhcf_pkg::in_item_t item_i,
  output logic               consume_o,
  output logic               snap_valid_o,
  output rhcf_pkg::snap_t    snap_o,
  input  logic               snap_ready_i
);

  logic [rhcf_pkg::POS_W-1:0] pos_q, pos_d;
  logic                       ovf_q, ovf_d;
  logic [15:0]                gs_q, gs_d;
  logic [7:0]                 hs_q, hs_d;
  logic [7:0]                 ot_q, ot_d;
  logic [7:0]                 os_q, os_d;
  logic [7:0]                 shc_q, shc_d;
  logic [15:0]                sgc_q, sgc_d;
  logic                       snap_valid_q, snap_valid_d;
  rhcf_pkg::snap_t            snap_q;

  logic [15:0]                gs_n;
  logic [7:0]                 hs_n, ot_n, os_n, shc_n;
  logic [15:0]                sgc_n;
  logic [7:0]                 lb;
  logic                       ovf_n;
  logic                       snap_free;
  logic                       capture;
  rhcf_pkg::snap_t            snap_n;

  assign snap_free = !snap_valid_q || snap_ready_i;
  assign consume_o = valid_i && (!item_i.last || snap_free);
  assign capture   = consume_o && item_i.last;

  always_comb begin
    gs_n  = gs_q;
    hs_n  = hs_q;
    ot_n  = ot_q;
    os_n  = os_q;
    shc_n = shc_q;
    sgc_n = sgc_q;
    lb    = rhcf_pkg::logo_byte(6'(pos_q - rhcf_pkg::LOGO_START));
    priority if (ovf_q) begin
      gs_n = gs_q + {8'h00, item_i.data};
    end else if (pos_q < rhcf_pkg::HDR_START) begin
      if (pos_q >= rhcf_pkg::LOGO_START) begin
        gs_n = gs_q + {8'h00, lb};
      end else begin
        gs_n = gs_q + {8'h00, item_i.data};
      end
    end else if (pos_q < rhcf_pkg::HCHK_POS) begin
      if (pos_q == rhcf_pkg::TYPE_POS) begin
        ot_n = item_i.data;
      end
      if (pos_q == rhcf_pkg::SIZE_POS) begin
        os_n = item_i.data;
      end
      hs_n = hs_q + item_i.data;
      gs_n = gs_q + {8'h00, item_i.data};
    end else if (pos_q == rhcf_pkg::HCHK_POS) begin
      shc_n = item_i.data;
    end else if (pos_q == rhcf_pkg::GCHK_HI_POS) begin
      sgc_n = {item_i.data, sgc_q[7:0]};
    end else if (pos_q == rhcf_pkg::GCHK_LO_POS) begin
      sgc_n = {sgc_q[15:8], item_i.data};
    end else begin
      gs_n = gs_q + {8'h00, item_i.data};
    end

    ovf_n = ovf_q || (pos_q == rhcf_pkg::POS_MAX);

    snap_n.global_sum  = gs_n;
    snap_n.header_sum  = hs_n;
    snap_n.orig_type   = ot_n;
    snap_n.orig_size   = os_n;
    snap_n.stored_hchk = shc_n;
    snap_n.stored_gchk = sgc_n;
    snap_n.length      = {1'b0, pos_q} + 25'd1;
    snap_n.overflow    = ovf_n;

    pos_d = pos_q;
    ovf_d = ovf_q;
    gs_d  = gs_q;
    hs_d  = hs_q;
    ot_d  = ot_q;
    os_d  = os_q;
    shc_d = shc_q;
    sgc_d = sgc_q;
    if (capture) begin
      pos_d = '0;
      ovf_d = 1'b0;
      gs_d  = '0;
      hs_d  = '0;
      ot_d  = '0;
      os_d  = '0;
      shc_d = '0;
      sgc_d = '0;
    end else if (consume_o) begin
      pos_d = (pos_q == rhcf_pkg::POS_MAX) ? pos_q : pos_q + 24'd1;
      ovf_d = ovf_n;
      gs_d  = gs_n;
      hs_d  = hs_n;
      ot_d  = ot_n;
      os_d  = os_n;
      shc_d = shc_n;
      sgc_d = sgc_n;
    end

    snap_valid_d = snap_valid_q;
    if (capture) begin
      snap_valid_d = 1'b1;
    end else if (snap_ready_i) begin
      snap_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      ovf_q        <= 1'b0;
      gs_q         <= '0;
      hs_q         <= '0;
      ot_q         <= '0;
      os_q         <= '0;
      shc_q        <= '0;
      sgc_q        <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      ovf_q        <= ovf_d;
      gs_q         <= gs_d;
      hs_q         <= hs_d;
      ot_q         <= ot_d;
      os_q         <= os_d;
      shc_q        <= shc_d;
      sgc_q        <= sgc_d;
      snap_valid_q <= snap_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      snap_q <= snap_n;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

endmodule

// ===== rtl/rhcf_finalize.sv =====
// ============================================================================
// ROM header checksum fix-up finishing stage
// Derives size code, fixed type and both checksums from the final snapshot
// and holds the result item in the output register.
// ============================================================================
module rhcf_finalize #(
  parameter int unsigned LENGTH_BITS = rhcf_pkg::LENGTH_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  snap_valid_i,
  input  rhcf_pkg::snap_t                       snap_i,
  output logic                                  snap_ready_o,
  output logic                                  m_valid_o,
  input  logic                                  m_ready_i,
  output logic [rhcf_pkg::OUT_TDATA_W-1:0]      m_data_o
);

  logic                                 out_valid_q, out_valid_d;
  logic [rhcf_pkg::OUT_TDATA_W-1:0]     out_data_q, out_data_d;
  logic                                 load;

  logic [3:0]                           code;
  logic [7:0]                           new_type;
  logic [7:0]                           hpre, hchk;
  logic [15:0]                          gsum, gchk;
  logic                                 err;
  logic [rhcf_pkg::LEN_W-1:0]           max_len;

  assign snap_ready_o = !out_valid_q || m_ready_i;
  assign load         = snap_valid_i && snap_ready_o;
  assign max_len      = rhcf_pkg::LEN_W'(1) << LENGTH_BITS;

  always_comb begin
    code = 4'd0;
    for (int k = 0; k < rhcf_pkg::CODE_STEPS; k++) begin
      code = code + {3'b000,
                     snap_i.length > (rhcf_pkg::LEN_W'(1) << (rhcf_pkg::BANK_BITS + k))};
    end

    new_type = snap_i.orig_type;
    if (snap_i.orig_type == 8'h00 && snap_i.length > rhcf_pkg::BANK_BYTES) begin
      new_type = 8'h01;
    end

    hpre = snap_i.header_sum - snap_i.orig_type - snap_i.orig_size + new_type
         + {4'h0, code};
    hchk = rhcf_pkg::HDR_BASE - hpre;
    gsum = snap_i.global_sum - {8'h00, snap_i.orig_type} - {8'h00, snap_i.orig_size}
         + {8'h00, new_type} + {12'h000, code};
    gchk = gsum + {8'h00, hchk};

    err = snap_i.overflow || (snap_i.length < rhcf_pkg::MIN_LENGTH)
       || (snap_i.length > max_len);

    out_data_d = '0;
    out_data_d[7:0]   = hchk;
    out_data_d[23:8]  = gchk;
    out_data_d[27:24] = code;
    out_data_d[35:28] = new_type;
    out_data_d[36]    = snap_i.stored_hchk != hchk;
    out_data_d[37]    = snap_i.stored_gchk != gchk;
    out_data_d[38]    = snap_i.orig_size != {4'h0, code};
    out_data_d[39]    = new_type != snap_i.orig_type;
    out_data_d[40]    = err;

    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;

endmodule

// ===== rtl/rom_header_checksum_fixup_top.sv =====
// ============================================================================
// ROM header checksum fix-up, top level
// The slave stream takes a ROM image one byte per item in address order from
// zero, with tlast on the final byte. Logo bytes are replaced by the fixed
// table, header and global sums are kept, and one result item leaves on the
// master stream for each image, after its last byte.
// The block accepts one byte every cycle while the input side is not stalled.
// The last byte of an image enters the input register when it is accepted;
// the accumulator snapshot register then takes the final state, and the
// output register loads the result item, which shows on the master stream.
// Bytes that are not last cause no result. After the last byte the counters
// and sums return to zero, so the next byte starts a new image at once.
// Reset clears the position counter, the sums and all valid flags; no image
// is in progress afterwards.
// When the receiver stalls, the result waits in the output register while
// bytes keep flowing; the input side stops only when a further last byte
// finds both the snapshot and the output register still occupied.
// ============================================================================
module rom_header_checksum_fixup_top #(
  parameter int unsigned LENGTH_BITS = rhcf_pkg::LENGTH_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] header_checksum, [23:8] global_checksum, [27:24] size_code,
  // [35:28] cart_type, [36] header_differs, [37] global_differs,
  // [38] size_differs, [39] type_changed, [40] length_error, [47:41] zero
  output logic [rhcf_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  rhcf_pkg::in_item_t s_item;
  rhcf_pkg::in_item_t in_item;
  logic               in_valid;
  logic               consume;
  logic               snap_valid;
  logic               snap_ready;
  rhcf_pkg::snap_t    snap;

  assign s_item.data = s_axis_tdata_i;
  assign s_item.last = s_axis_tlast_i;

  rhcf_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_item_i  (s_item),
    .valid_o   (in_valid),
    .item_o    (in_item),
    .consume_i (consume)
  );

  rhcf_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid),
    .item_i       (in_item),
    .consume_o    (consume),
    .snap_valid_o (snap_valid),
    .snap_o       (snap),
    .snap_ready_i (snap_ready)
  );

  rhcf_finalize #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_finalize (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_i       (snap),
    .snap_ready_o (snap_ready),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .m_data_o     (m_axis_tdata_o)
  );

endmodule
